### hw/rtl/clcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcr_pkg
// Shared types, sizes and helpers for the circular list cursor ring.
// ----------------------------------------------------------------------------
package clcr_pkg;

  localparam int CAPACITY = 16;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic rd;      // item accepted: latch it and read the next front slot
    logic commit;  // finish the item: update state and load the result
  } clcr_cmd_t;

  typedef struct packed {
    data_t            front_value;
    data_t            back_value;
    logic             is_empty;
    logic [OCC_W-1:0] occupancy;
    logic             error;
  } out_item_t;

  // slot index (ptr + off) modulo CAPACITY, off at most CAPACITY
  function automatic ptr_t wrap_add(input ptr_t ptr, input cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(ptr) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return PTR_W'(sum);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/clcr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcr_if
// Valid/ready channels carrying list operations and list status results.
// ----------------------------------------------------------------------------
interface clcr_in_if
  import clcr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface clcr_out_if
  import clcr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic                     is_empty;
  logic [OCC_W-1:0]         occupancy;
  logic                     error;

  modport source (output valid, output front_value, output back_value, output is_empty,
                  output occupancy, output error, input ready);
  modport sink   (input valid, input front_value, input back_value, input is_empty,
                  input occupancy, input error, output ready);
endinterface
`default_nettype wire

### hw/rtl/clcr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcr_ctrl
// Two-state sequencer: take an item, then finish it into the output register.
// ----------------------------------------------------------------------------
module clcr_ctrl
  import clcr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      clcr_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_POST
  } state_t;

  state_t state;
  logic   accept;
  logic   post_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // result register must be free or emptying before it is overwritten
  assign post_go  = (state == S_POST) && (!out_valid || out_ready);

  assign cmd.rd     = accept;
  assign cmd.commit = post_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (post_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (post_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_to_post: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_POST))
    else $error("accepted item did not move to post state");

  a_commit_loads_result: assert property (@(posedge clk) disable iff (rst)
    post_go |=> out_valid)
    else $error("finished item did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !post_go)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

### hw/rtl/clcr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcr_dp
// Ring store, front pointer, count, cached front/back values, result register.
// ----------------------------------------------------------------------------
module clcr_dp
  import clcr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire clcr_cmd_t        cmd,
  input  wire logic [OP_W-1:0]  opcode,
  input  wire data_t            value,
  output      out_item_t        result
);

  localparam cnt_t OFF_ONE  = CNT_W'(1);
  localparam cnt_t OFF_BACK = CNT_W'(CAPACITY - 1);
  localparam cnt_t CNT_FULL = CNT_W'(CAPACITY);

  data_t            mem [CAPACITY];
  data_t            rdata;
  ptr_t             fp;
  ptr_t             fp_next;
  cnt_t             count;
  cnt_t             count_next;
  data_t            front_reg;
  data_t            front_next;
  data_t            back_reg;
  data_t            back_next;
  logic [OP_W-1:0]  op_q;
  data_t            val_q;
  logic             err;
  logic             we;
  ptr_t             waddr;
  data_t            wdata;

  // read the slot after the front while the item is taken
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[wrap_add(fp, OFF_ONE)];
      op_q  <= opcode;
      val_q <= value;
    end
    if (cmd.commit && we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    fp_next    = fp;
    count_next = count;
    front_next = front_reg;
    back_next  = back_reg;
    err        = 1'b0;
    we         = 1'b0;
    waddr      = fp;
    wdata      = val_q;
    case (op_q)
      OP_ADD: begin
        if (count == CNT_FULL) begin
          err = 1'b1;
        end else begin
          fp_next    = wrap_add(fp, OFF_BACK);
          count_next = count + OFF_ONE;
          front_next = val_q;
          back_next  = (count == '0) ? val_q : back_reg;
          we         = 1'b1;
          waddr      = fp_next;
          wdata      = val_q;
        end
      end
      OP_REMOVE: begin
        if (count == '0) begin
          err = 1'b1;
        end else begin
          fp_next    = wrap_add(fp, OFF_ONE);
          count_next = count - OFF_ONE;
          front_next = rdata;
        end
      end
      OP_ADVANCE: begin
        if (count == '0) begin
          err = 1'b1;
        end else begin
          fp_next    = wrap_add(fp, OFF_ONE);
          // single element: the slot read ahead holds no list element
          front_next = (count == OFF_ONE) ? front_reg : rdata;
          back_next  = front_reg;
          we         = 1'b1;
          waddr      = wrap_add(fp, count);
          wdata      = front_reg;
        end
      end
      default: err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp    <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      fp    <= fp_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      front_reg          <= front_next;
      back_reg           <= back_next;
      result.front_value <= (count_next == '0) ? '0 : front_next;
      result.back_value  <= (count_next == '0) ? '0 : back_next;
      result.is_empty    <= (count_next == '0);
      result.occupancy   <= OCC_W'(count_next);
      result.error       <= err;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("element count above capacity");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && err) |=> (count == $past(count) && fp == $past(fp)))
    else $error("refused operation changed the list");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !err && op_q == OP_ADD) |=> (count == $past(count) + OFF_ONE))
    else $error("add did not grow the list by one");

endmodule
`default_nettype wire

### hw/rtl/circular_list_cursor_ring_core.sv
`default_nettype none
// A result is registered: a taken item is finished from the post state into the result register.
// The core takes no new item until the last one is finished: the next front slot is read
//   when an item is taken, then the rotated element is written when it is finished.
// A full result register stalls the item until the result transfers.
// Reset: front pointer and count clear at once; store contents stay undefined,
//   no clearing pass, items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// circular_list_cursor_ring_core
// Bounded circular list with a cursor held in a ring buffer.
// ----------------------------------------------------------------------------
module circular_list_cursor_ring_core
  import clcr_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  clcr_in_if.sink   cmd,
  clcr_out_if.source rsp
);

  clcr_cmd_t dp_cmd;
  out_item_t result;

  clcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (dp_cmd)
  );

  clcr_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (dp_cmd),
    .opcode (cmd.opcode),
    .value  (cmd.value),
    .result (result)
  );

  assign rsp.front_value = result.front_value;
  assign rsp.back_value  = result.back_value;
  assign rsp.is_empty    = result.is_empty;
  assign rsp.occupancy   = result.occupancy;
  assign rsp.error       = result.error;

endmodule
`default_nettype wire
